// ===== sv/decimal_radix_sorter_macros.svh =====
// Assertion macros for the decimal radix sorter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef DECIMAL_RADIX_SORTER_MACROS_SVH
`define DECIMAL_RADIX_SORTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/drs_pkg.sv =====
// Shared constants and types of the decimal radix sorter.
// No dependencies; used by drs_cell and decimal_radix_sorter.
package drs_pkg;

    // Default sizes of the sorter
    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed width of the value fields on the ports
    localparam int DATA_W = 16;

    // Control that the sequencer hands to every cell
    typedef struct packed {
        logic load;   // accept and ripple inserted items
        logic shift;  // move held items one cell toward the output
    } t_cell_ctrl;

endpackage

// ===== sv/decimal_radix_sorter.sv =====
// Top level of the decimal radix sorter: a row of sorting cells and the
// load / settle / emit sequencer. Uses drs_pkg, drs_cell and the macros header.
//
//  channel   | dir | tdata            | tlast        | tuser
//  s_axis    | in  | [15:0] value     | last_item    | -
//  m_axis    | out | [15:0] sorted    | last_result  | [0] dropped
//
// Load: one item per cycle; items beyond MAX_ITEMS are dropped and flagged.
// After the last item the row settles, which gives a displaced value time
// to ripple down the whole cell row.
// Emit: one result per cycle while the output is ready, smallest first; input is held off meanwhile.
// A stalled output holds the row; reset (synchronous, active low) empties it.
`include "decimal_radix_sorter_macros.svh"

module decimal_radix_sorter #(
    parameter int MAX_ITEMS  = drs_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = drs_pkg::DEF_VALUE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [drs_pkg::DATA_W-1:0] i_s_axis_tdata,  // [15:0] value
    input  logic                       i_s_axis_tlast,  // last_item
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [drs_pkg::DATA_W-1:0] o_m_axis_tdata,  // [15:0] sorted_value
    output logic                       o_m_axis_tlast,  // last_result
    output logic                       o_m_axis_tuser   // [0] dropped
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_settle;
    logic                r_overflow;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_room;
    drs_pkg::t_cell_ctrl w_ctrl;

    logic                  w_full      [MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_val       [MAX_ITEMS];
    logic                  w_pass_valid[MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_pass_val  [MAX_ITEMS];

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_room          = (r_count < CNT_W'(MAX_ITEMS));

    assign o_m_axis_tvalid = (r_state == ST_EMIT);
    assign w_out_acc       = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = drs_pkg::DATA_W'(w_val[0]);
    assign o_m_axis_tlast  = !w_full[1];
    assign o_m_axis_tuser  = r_overflow;

    assign w_ctrl.load  = (r_state != ST_EMIT);
    assign w_ctrl.shift = w_out_acc;

    // Build the row of cells; the first takes items from the input port
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                  w_in_valid;
        logic [VALUE_BITS-1:0] w_in_val;
        logic                  w_nb_full;
        logic [VALUE_BITS-1:0] w_nb_val;

        if (g == 0) begin : g_first
            assign w_in_valid = w_in_acc && w_room;
            assign w_in_val   = VALUE_BITS'(i_s_axis_tdata);
        end else begin : g_inner
            assign w_in_valid = w_pass_valid[g-1];
            assign w_in_val   = w_pass_val[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_nb_full = 1'b0;
            assign w_nb_val  = '0;
        end else begin : g_body
            assign w_nb_full = w_full[g+1];
            assign w_nb_val  = w_val[g+1];
        end

        drs_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_in_valid  (w_in_valid),
            .i_in_val    (w_in_val),
            .i_nb_full   (w_nb_full),
            .i_nb_val    (w_nb_val),
            .o_pass_valid(w_pass_valid[g]),
            .o_pass_val  (w_pass_val[g]),
            .o_full      (w_full[g]),
            .o_val       (w_val[g])
        );
    end

    // Sequence load, settle and emit; count items and flag drops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_settle   <= '0;
            r_overflow <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_state  <= ST_SETTLE;
                            r_settle <= '0;
                        end
                    end
                end
                ST_SETTLE: begin
                    r_settle <= r_settle + CNT_W'(1);
                    if (r_settle == CNT_W'(MAX_ITEMS)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc && o_m_axis_tlast) begin
                        r_state    <= ST_LOAD;
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // Checks on the sequencer and the cell row
    `DRS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ITEMS), "item count overran")
    `DRS_ASSERT_SAME(a_emit_full, r_state == ST_EMIT, w_full[0], "emitting from an empty cell")
    `DRS_ASSERT_NEXT(a_last_frees, w_out_acc && o_m_axis_tlast, o_s_axis_tready && !w_full[0],
                     "row not empty after last result")
    `DRS_ASSERT_SAME(a_drop_full, w_in_acc && !w_room, w_full[MAX_ITEMS-1] || r_state == ST_LOAD,
                     "drop while row not full")

endmodule

// ===== sv/drs_cell.sv =====
// One cell of the sorting row: holds one value, keeps the smaller of held
// and incoming, and hands the larger to its right neighbor. Uses drs_pkg.
module drs_cell #(
    parameter int VALUE_BITS = drs_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  drs_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_in_valid,   // item from the left neighbor
    input  logic [VALUE_BITS-1:0] i_in_val,
    input  logic                  i_nb_full,    // held item of the right neighbor
    input  logic [VALUE_BITS-1:0] i_nb_val,
    output logic                  o_pass_valid, // item handed to the right
    output logic [VALUE_BITS-1:0] o_pass_val,
    output logic                  o_full,
    output logic [VALUE_BITS-1:0] o_val
);

    logic                  r_full;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_pass_valid;
    logic [VALUE_BITS-1:0] r_pass_val;

    // Insert, compare and pass on, or shift toward the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= 1'b0;
            r_pass_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_full       <= i_nb_full;
            r_val        <= i_nb_val;
            r_pass_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_pass_valid <= 1'b0;
            if (i_in_valid) begin
                if (!r_full) begin
                    r_full <= 1'b1;
                    r_val  <= i_in_val;
                end else if (i_in_val < r_val) begin
                    r_val        <= i_in_val;
                    r_pass_val   <= r_val;
                    r_pass_valid <= 1'b1;
                end else begin
                    r_pass_val   <= i_in_val;
                    r_pass_valid <= 1'b1;
                end
            end
        end
    end

    assign o_pass_valid = r_pass_valid;
    assign o_pass_val   = r_pass_val;
    assign o_full       = r_full;
    assign o_val        = r_val;

endmodule
